// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication after a fixed delay
`define ASSERT_DELAY(lbl, clk, rst, ante, dly, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/gnpt_pkg.sv -----
// ----------------------------------------------------------------------------
// gnpt_pkg
// Types, constants and arithmetic helpers of the gradient noise threshold.
// ----------------------------------------------------------------------------
package gnpt_pkg;

  localparam int COORD_W     = 12;
  localparam int RECIP_W     = 25;
  localparam int GAIN_W      = 16;
  localparam int NOISE_W     = 16;
  localparam int GRAY_W      = 8;
  localparam int POS_W       = COORD_W + RECIP_W;
  localparam int CELL_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int DX_W        = FRAC_W + 2;
  localparam int GRAD_W      = 16;
  localparam int DOT_W       = 18;
  localparam int SMOOTH_W    = 17;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 25;
  localparam int LATENCY     = 15;

  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int OCTAVES          = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_GRID_RECIPROCAL = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CONTRAST_GAIN   = 2'd1;

  localparam logic [RECIP_W-1:0] RECIP_RESET = 25'd49200;
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd19661;

  localparam logic [31:0] HASH_M1 = 32'd3284157443;
  localparam logic [31:0] HASH_M2 = 32'd1911520717;
  localparam logic [31:0] HASH_M3 = 32'd2048419325;

  localparam logic [16:0] POLY_C1 = 17'd102944;
  localparam logic [15:0] POLY_C3 = 16'd42334;
  localparam logic [12:0] POLY_C5 = 13'd4926;

  localparam logic [15:0] ONE_Q14  = 16'd16384;
  localparam logic [7:0]  GRAY_ON  = 8'd255;
  localparam logic [7:0]  GRAY_OFF = 8'd0;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
  } pixel_t;

  typedef struct packed {
    logic signed [NOISE_W-1:0] noise_value;
    logic [GRAY_W-1:0]         gray_value;
  } result_t;

  function automatic logic [31:0] rot16(input logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  function automatic logic signed [DOT_W-1:0] blend(input logic signed [DOT_W-1:0] a0,
                                                    input logic signed [DOT_W-1:0] a1,
                                                    input logic [SMOOTH_W-1:0] s);
    logic signed [DOT_W:0]    d;
    logic signed [DOT_W+18:0] p;
    d = (DOT_W+1)'(a1) - (DOT_W+1)'(a0);
    p = (DOT_W+19)'(d) * (DOT_W+19)'($signed({1'b0, s}));
    return DOT_W'((DOT_W+19)'(a0) + (p >>> 16));
  endfunction

endpackage

// ----- rtl/core/gnpt_corner.sv -----
// ----------------------------------------------------------------------------
// gnpt_corner
// Corner hash, gradient from the sine polynomial and dot product; 8 stages.
// ----------------------------------------------------------------------------
module gnpt_corner #(
  parameter int SINE_TABLE_DEPTH = gnpt_pkg::SINE_TABLE_DEPTH
) (
  input  logic                                 clk,
  input  logic [gnpt_pkg::CELL_W-1:0]          cx,
  input  logic [gnpt_pkg::CELL_W-1:0]          cy,
  input  logic signed [gnpt_pkg::DX_W-1:0]     dx,
  input  logic signed [gnpt_pkg::DX_W-1:0]     dy,
  output logic signed [gnpt_pkg::DOT_W-1:0]    dot
);

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH);

  logic [31:0] a1, cy1, a2, b2, h3;
  logic [17:0] q;
  logic [1:0]  quad;
  logic [16:0] u, us, uc;
  logic [33:0] sqs, sqc;
  logic [16:0] xs4, xc4, us4, uc4, us5, uc5, us6, uc6;
  logic        ns4, nc4, ns5, nc5, ns6, nc6;
  logic [29:0] ps5, pc5;
  logic [15:0] ts5, tc5;
  logic [32:0] ps6, pc6;
  logic [16:0] xs5, xc5, ts6, tc6;
  logic [33:0] ms7, mc7;
  logic [15:0] mags, magc;
  logic signed [gnpt_pkg::GRAD_W-1:0] gx7, gy7;
  logic signed [gnpt_pkg::DX_W-1:0]   dxd [0:6];
  logic signed [gnpt_pkg::DX_W-1:0]   dyd [0:6];
  logic signed [34:0] acc;

  always_comb begin
    q    = 18'(h3[31 -: IDX_W]) << (18 - IDX_W);
    quad = q[17:16];
    u    = {1'b0, q[15:0]};
    us   = quad[0] ? 17'd65536 - u : u;
    uc   = quad[0] ? u : 17'd65536 - u;
    sqs  = 34'(us) * 34'(us);
    sqc  = 34'(uc) * 34'(uc);
    ps5  = 30'(xs4) * 30'(gnpt_pkg::POLY_C5);
    pc5  = 30'(xc4) * 30'(gnpt_pkg::POLY_C5);
    ps6  = 33'(xs5) * 33'(ts5);
    pc6  = 33'(xc5) * 33'(tc5);
    ms7  = 34'(us6) * 34'(ts6);
    mc7  = 34'(uc6) * 34'(tc6);
    mags = (ms7[33:18] > gnpt_pkg::ONE_Q14) ? gnpt_pkg::ONE_Q14 : ms7[33:18];
    magc = (mc7[33:18] > gnpt_pkg::ONE_Q14) ? gnpt_pkg::ONE_Q14 : mc7[33:18];
    acc  = 35'(dxd[6]) * 35'(gx7) + 35'(dyd[6]) * 35'(gy7);
  end

  always_ff @(posedge clk) begin
    a1  <= 32'(cx * gnpt_pkg::HASH_M1);
    cy1 <= cy;
    b2  <= 32'((cy1 ^ gnpt_pkg::rot16(a1)) * gnpt_pkg::HASH_M2);
    a2  <= a1;
    h3  <= 32'((a2 ^ gnpt_pkg::rot16(b2)) * gnpt_pkg::HASH_M3);
    xs4 <= sqs[32:16];
    xc4 <= sqc[32:16];
    us4 <= us;
    uc4 <= uc;
    ns4 <= quad[1];
    nc4 <= quad[1] ^ quad[0];
    ts5 <= gnpt_pkg::POLY_C3 - ps5[29:16];
    tc5 <= gnpt_pkg::POLY_C3 - pc5[29:16];
    xs5 <= xs4;
    xc5 <= xc4;
    us5 <= us4;
    uc5 <= uc4;
    ns5 <= ns4;
    nc5 <= nc4;
    ts6 <= gnpt_pkg::POLY_C1 - ps6[32:16];
    tc6 <= gnpt_pkg::POLY_C1 - pc6[32:16];
    us6 <= us5;
    uc6 <= uc5;
    ns6 <= ns5;
    nc6 <= nc5;
    gx7 <= ns6 ? -$signed(mags) : $signed(mags);
    gy7 <= nc6 ? -$signed(magc) : $signed(magc);
    dot <= gnpt_pkg::DOT_W'(acc >>> 16);
    dxd[0] <= dx;
    dyd[0] <= dy;
    for (int i = 1; i < 7; i++) begin
      dxd[i] <= dxd[i-1];
      dyd[i] <= dyd[i-1];
    end
  end

endmodule

// ----- rtl/core/gnpt_octave.sv -----
// ----------------------------------------------------------------------------
// gnpt_octave
// One noise octave: cell split, four corners, smoothstep and bilinear blend.
// ----------------------------------------------------------------------------
module gnpt_octave #(
  parameter int OCT              = 0,
  parameter int SINE_TABLE_DEPTH = gnpt_pkg::SINE_TABLE_DEPTH
) (
  input  logic                               clk,
  input  logic [gnpt_pkg::POS_W-1:0]         posx,
  input  logic [gnpt_pkg::POS_W-1:0]         posy,
  output logic signed [gnpt_pkg::DOT_W-1:0]  noise
);

  localparam int SW = gnpt_pkg::POS_W + OCT;

  logic [SW-1:0] fullx, fully;
  logic [gnpt_pkg::CELL_W-1:0] x0, y0, x1, y1;
  logic [gnpt_pkg::FRAC_W-1:0] fx, fy;
  logic signed [gnpt_pkg::DX_W-1:0] dx0, dy0, dx1, dy1;
  logic signed [gnpt_pkg::DOT_W-1:0] d00, d10, d01, d11, top, bot;
  logic [15:0] w2x, w2y;
  logic [17:0] tx, ty;
  logic [31:0] sqx, sqy;
  logic [33:0] smx, smy;
  logic [gnpt_pkg::SMOOTH_W-1:0] svx, svy;
  logic [gnpt_pkg::SMOOTH_W-1:0] sxd [0:5];
  logic [gnpt_pkg::SMOOTH_W-1:0] syd [0:6];

  always_comb begin
    fullx = SW'(posx) << OCT;
    fully = SW'(posy) << OCT;
    x0    = gnpt_pkg::CELL_W'(fullx >> 24);
    y0    = gnpt_pkg::CELL_W'(fully >> 24);
    x1    = x0 + 32'd1;
    y1    = y0 + 32'd1;
    fx    = fullx[23:8];
    fy    = fully[23:8];
    dx0   = $signed({2'b00, fx});
    dy0   = $signed({2'b00, fy});
    dx1   = dx0 - 18'sd65536;
    dy1   = dy0 - 18'sd65536;
    sqx   = 32'(fx) * 32'(fx);
    sqy   = 32'(fy) * 32'(fy);
    smx   = 34'(w2x) * 34'(tx);
    smy   = 34'(w2y) * 34'(ty);
  end

  gnpt_corner #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_c00 (
    .clk(clk), .cx(x0), .cy(y0), .dx(dx0), .dy(dy0), .dot(d00));
  gnpt_corner #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_c10 (
    .clk(clk), .cx(x1), .cy(y0), .dx(dx1), .dy(dy0), .dot(d10));
  gnpt_corner #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_c01 (
    .clk(clk), .cx(x0), .cy(y1), .dx(dx0), .dy(dy1), .dot(d01));
  gnpt_corner #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_c11 (
    .clk(clk), .cx(x1), .cy(y1), .dx(dx1), .dy(dy1), .dot(d11));

  always_ff @(posedge clk) begin
    w2x <= sqx[31:16];
    w2y <= sqy[31:16];
    tx  <= 18'd196608 - {1'b0, fx, 1'b0};
    ty  <= 18'd196608 - {1'b0, fy, 1'b0};
    svx <= smx[32:16];
    svy <= smy[32:16];
    sxd[0] <= svx;
    syd[0] <= svy;
    for (int i = 1; i < 6; i++) begin
      sxd[i] <= sxd[i-1];
    end
    for (int i = 1; i < 7; i++) begin
      syd[i] <= syd[i-1];
    end
    top   <= gnpt_pkg::blend(d00, d10, sxd[5]);
    bot   <= gnpt_pkg::blend(d01, d11, sxd[5]);
    noise <= gnpt_pkg::blend(top, bot, syd[6]);
  end

endmodule

// ----- rtl/core/gradient_noise_pixel_threshold.sv -----
// ----------------------------------------------------------------------------
// gradient_noise_pixel_threshold
// A valid shift register carries each start transfer to the result strobe.
// Throughput: one pixel per cycle; busy is low except during reset.
// The length of the multiply pipeline (hash, sine polynomial, blends) sets latency.
// Reset clears the pipeline valid bits and loads the default configuration.
// ----------------------------------------------------------------------------
module gradient_noise_pixel_threshold #(
  parameter int SINE_TABLE_DEPTH = gnpt_pkg::SINE_TABLE_DEPTH,
  parameter int OCTAVES          = gnpt_pkg::OCTAVES
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  gnpt_pkg::pixel_t                    pixel,
  output logic                                result_strobe,
  output gnpt_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gnpt_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [gnpt_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SUM_W  = gnpt_pkg::DOT_W + 1;
  localparam int PROD_W = SUM_W + gnpt_pkg::GAIN_W + 1;

  logic [gnpt_pkg::RECIP_W-1:0] recip;
  logic [gnpt_pkg::GAIN_W-1:0]  gain;
  logic [gnpt_pkg::LATENCY-1:0] vld;
  logic accept;

  logic [gnpt_pkg::COORD_W-1:0] px, py;
  logic [gnpt_pkg::POS_W-1:0]   posx, posy;
  logic signed [gnpt_pkg::DOT_W-1:0] noise [OCTAVES];
  logic signed [SUM_W-1:0]  sum_c, sum_q;
  logic signed [PROD_W-1:0] prod_c, prod_q;
  logic signed [gnpt_pkg::NOISE_W-1:0] clip;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign result_strobe = vld[gnpt_pkg::LATENCY-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      recip <= gnpt_pkg::RECIP_RESET;
      gain  <= gnpt_pkg::GAIN_RESET;
      vld   <= '0;
    end else begin
      vld <= {vld[gnpt_pkg::LATENCY-2:0], accept};
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          gnpt_pkg::REG_GRID_RECIPROCAL: recip <= cfg_data;
          gnpt_pkg::REG_CONTRAST_GAIN:   gain  <= cfg_data[gnpt_pkg::GAIN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  generate
    for (genvar o = 0; o < OCTAVES; o++) begin : g_oct
      gnpt_octave #(.OCT(o), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_oct (
        .clk(clk), .posx(posx), .posy(posy), .noise(noise[o]));
    end
  endgenerate

  always_comb begin
    sum_c = '0;
    for (int o = 0; o < OCTAVES; o++) begin
      sum_c = sum_c + (SUM_W'(noise[o]) >>> o);
    end
    prod_c = PROD_W'(sum_q) * PROD_W'($signed({1'b0, gain}));
    if (prod_q > $signed(PROD_W'(gnpt_pkg::ONE_Q14))) begin
      clip = $signed(gnpt_pkg::ONE_Q14);
    end else if (prod_q < -$signed(PROD_W'(gnpt_pkg::ONE_Q14))) begin
      clip = -$signed(gnpt_pkg::ONE_Q14);
    end else begin
      clip = gnpt_pkg::NOISE_W'(prod_q);
    end
  end

  always_ff @(posedge clk) begin
    px     <= pixel.pixel_x;
    py     <= pixel.pixel_y;
    posx   <= gnpt_pkg::POS_W'(px) * gnpt_pkg::POS_W'(recip);
    posy   <= gnpt_pkg::POS_W'(py) * gnpt_pkg::POS_W'(recip);
    sum_q  <= sum_c;
    prod_q <= prod_c >>> 14;
    result.noise_value <= clip;
    result.gray_value  <= (clip > 0) ? gnpt_pkg::GRAY_ON : gnpt_pkg::GRAY_OFF;
  end

endmodule

// ----- rtl/core/gnpt_checker.sv -----
// ----------------------------------------------------------------------------
// gnpt_checker
// Port-level checks on timing and result consistency, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gnpt_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              result_strobe,
  input gnpt_pkg::result_t result
);

  localparam int LAT = gnpt_pkg::LATENCY;

  `ASSERT_DELAY(a_result_follows, clk, rst, start && !busy, LAT, result_strobe)
  `ASSERT_IMPLY(a_no_spurious, clk, rst, result_strobe, $past(start && !busy, LAT))
  `ASSERT_IMPLY(a_gray_match, clk, rst, result_strobe, (result.gray_value == gnpt_pkg::GRAY_ON) == (result.noise_value > 0))
  `ASSERT_IMPLY(a_range, clk, rst, result_strobe, result.noise_value <= 16384 && result.noise_value >= -16384)

endmodule

bind gradient_noise_pixel_threshold gnpt_checker u_gnpt_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .result_strobe(result_strobe),
  .result(result)
);

// ----- sim/tb_gradient_noise_pixel_threshold.sv -----
// ----------------------------------------------------------------------------
// tb_gradient_noise_pixel_threshold
// Streams pixel coordinates through the noise threshold block under several
// grid and contrast settings. A built-in fixed-point predictor computes the
// expected noise and gray byte of every start transfer. A monitor compares
// each result strobe against the oldest expectation.
// ----------------------------------------------------------------------------
module tb_gradient_noise_pixel_threshold;

  typedef enum logic [1:0] {JOB_PIXEL, JOB_CFG, JOB_DRAIN} job_kind_t;

  typedef struct {
    job_kind_t                               kind;
    gnpt_pkg::pixel_t                        pix;
    logic [gnpt_pkg::CFG_INDEX_W-1:0]        idx;
    logic [gnpt_pkg::CFG_DATA_W-1:0]         data;
    bit                                      no_gap;
  } job_t;

  localparam int QUIET_CYCLES = gnpt_pkg::LATENCY + 5;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [gnpt_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [gnpt_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  gnpt_pkg::pixel_t pixel = '0;
  logic result_strobe;
  gnpt_pkg::result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [gnpt_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [gnpt_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  job_t job_q[$];
  gnpt_pkg::result_t noise_q[$];
  logic [gnpt_pkg::RECIP_W-1:0] recip_m = gnpt_pkg::RECIP_RESET;
  logic [gnpt_pkg::GAIN_W-1:0] gain_m = gnpt_pkg::GAIN_RESET;
  int quiet_cnt = 0;
  int idle_cnt = 0;
  int pixels_sent = 0;
  int cfg_writes = 0;
  int results_seen = 0;
  int positive_seen = 0;
  int errors = 0;

  gradient_noise_pixel_threshold uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .pixel(pixel),
    .result_strobe(result_strobe), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint quarter_wave(longint u);
    longint x2, t, s;
    x2 = (u * u) >> 16;
    t = 42334 - ((x2 * 4926) >> 16);
    t = 102944 - ((x2 * t) >> 16);
    s = ((u * t) >> 16) >> 2;
    return (s > 16384) ? 64'sd16384 : s;
  endfunction

  function automatic longint sine_of(longint q);
    longint quad, u, m;
    quad = (q >> 16) & 3;
    u = q & 16'hFFFF;
    m = quad[0] ? quarter_wave(65536 - u) : quarter_wave(u);
    return quad[1] ? -m : m;
  endfunction

  function automatic longint gradient_dot(logic [31:0] cx, logic [31:0] cy,
                                          longint dx, longint dy);
    logic [31:0] a, b;
    longint q;
    a = cx * gnpt_pkg::HASH_M1;
    b = cy ^ {a[15:0], a[31:16]};
    b = b * gnpt_pkg::HASH_M2;
    a = a ^ {b[15:0], b[31:16]};
    a = a * gnpt_pkg::HASH_M3;
    q = longint'(a[31:22]) * 256;
    return (dx * sine_of(q) + dy * sine_of(q + 65536)) >>> 16;
  endfunction

  function automatic longint lerp_q16(longint a0, longint a1, longint s);
    return a0 + (((a1 - a0) * s) >>> 16);
  endfunction

  function automatic longint fade(longint w);
    return (((w * w) >> 16) * (3 * 65536 - 2 * w)) >> 16;
  endfunction

  function automatic longint octave_noise(longint px, longint py, int oct);
    longint posx, posy, fx, fy, sx, sy, top, bot;
    logic [31:0] x0, y0;
    posx = (px * longint'(recip_m)) << oct;
    posy = (py * longint'(recip_m)) << oct;
    x0 = posx[55:24];
    y0 = posy[55:24];
    fx = (posx >> 8) & 16'hFFFF;
    fy = (posy >> 8) & 16'hFFFF;
    sx = fade(fx);
    sy = fade(fy);
    top = lerp_q16(gradient_dot(x0, y0, fx, fy),
                   gradient_dot(x0 + 1, y0, fx - 65536, fy), sx);
    bot = lerp_q16(gradient_dot(x0, y0 + 1, fx, fy - 65536),
                   gradient_dot(x0 + 1, y0 + 1, fx - 65536, fy - 65536), sx);
    return lerp_q16(top, bot, sy);
  endfunction

  function automatic gnpt_pkg::result_t threshold_noise(gnpt_pkg::pixel_t p);
    longint acc;
    gnpt_pkg::result_t r;
    acc = 0;
    for (int o = 0; o < gnpt_pkg::OCTAVES; o++) begin
      acc += octave_noise(longint'(p.pixel_x), longint'(p.pixel_y), o) >>> o;
    end
    acc = (acc * longint'(gain_m)) >>> 14;
    if (acc > 16384) acc = 16384;
    else if (acc < -16384) acc = -16384;
    r.noise_value = acc[15:0];
    r.gray_value = (acc > 0) ? gnpt_pkg::GRAY_ON : gnpt_pkg::GRAY_OFF;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    bit took, wrote, n_start, n_cfg;
    job_t j;
    if (!rst) begin
      took = start && !busy;
      wrote = cfg_valid && cfg_ready;
      n_start = start && !took;
      n_cfg = cfg_valid && !wrote;
      if (took) begin
        noise_q.push_back(threshold_noise(pixel));
        pixels_sent++;
      end
      if (wrote) begin
        cfg_writes++;
        if (cfg_index == gnpt_pkg::REG_GRID_RECIPROCAL) recip_m = cfg_data;
        else if (cfg_index == gnpt_pkg::REG_CONTRAST_GAIN)
          gain_m = cfg_data[gnpt_pkg::GAIN_W-1:0];
      end
      if (noise_q.size() == 0 && !n_start) quiet_cnt++;
      else quiet_cnt = 0;
      if (!n_start && !n_cfg && job_q.size() > 0) begin
        j = job_q[0];
        case (j.kind)
          JOB_PIXEL: begin
            if (j.no_gap || $urandom_range(99) >= 18) begin
              n_start = 1'b1;
              pixel <= j.pix;
              void'(job_q.pop_front());
            end
          end
          JOB_CFG: begin
            if (quiet_cnt >= QUIET_CYCLES && $urandom_range(99) >= 18) begin
              n_cfg = 1'b1;
              cfg_index <= j.idx;
              cfg_data <= j.data;
              void'(job_q.pop_front());
            end
          end
          default: begin
            if (quiet_cnt > 0) void'(job_q.pop_front());
          end
        endcase
      end
      start <= n_start;
      cfg_valid <= n_cfg;
    end
  end

  // monitor
  always @(posedge clk) begin
    gnpt_pkg::result_t want;
    if (!rst && result_strobe) begin
      results_seen++;
      if (noise_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result noise=%0d gray=%0d", result.noise_value,
                   result.gray_value);
      end else begin
        want = noise_q.pop_front();
        if (want.noise_value > 0) positive_seen++;
        if (result.noise_value !== want.noise_value ||
            result.gray_value !== want.gray_value) begin
          errors++;
          if (errors <= 10)
            $display("mismatch noise exp=%0d act=%0d gray exp=%0d act=%0d",
                     want.noise_value, result.noise_value, want.gray_value,
                     result.gray_value);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (start && !busy) || (cfg_valid && cfg_ready) || result_strobe) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("timeout with %0d results outstanding", noise_q.size());
      $display("FAIL gradient_noise_pixel_threshold");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  function automatic gnpt_pkg::pixel_t rand_pixel();
    gnpt_pkg::pixel_t p;
    case ($urandom_range(3))
      0: begin
        p.pixel_x = gnpt_pkg::COORD_W'($urandom_range(63));
        p.pixel_y = gnpt_pkg::COORD_W'($urandom_range(63));
      end
      1: begin
        p.pixel_x = gnpt_pkg::COORD_W'(4095 - $urandom_range(15));
        p.pixel_y = gnpt_pkg::COORD_W'($urandom_range(4095));
      end
      default: begin
        p.pixel_x = gnpt_pkg::COORD_W'($urandom_range(4095));
        p.pixel_y = gnpt_pkg::COORD_W'($urandom_range(4095));
      end
    endcase
    return p;
  endfunction

  task automatic add_pixel(logic [gnpt_pkg::COORD_W-1:0] x,
                           logic [gnpt_pkg::COORD_W-1:0] y, bit ng);
    job_t j;
    j.kind = JOB_PIXEL;
    j.pix.pixel_x = x;
    j.pix.pixel_y = y;
    j.idx = '0;
    j.data = '0;
    j.no_gap = ng;
    job_q.push_back(j);
  endtask

  task automatic add_write(logic [gnpt_pkg::CFG_INDEX_W-1:0] idx,
                           logic [gnpt_pkg::CFG_DATA_W-1:0] d);
    job_t j;
    j.kind = JOB_CFG;
    j.pix = '0;
    j.idx = idx;
    j.data = d;
    j.no_gap = 1'b0;
    job_q.push_back(j);
  endtask

  task automatic add_phase(logic [gnpt_pkg::CFG_DATA_W-1:0] recip,
                           logic [gnpt_pkg::CFG_DATA_W-1:0] gain,
                           int count, bit calm);
    job_t j;
    gnpt_pkg::pixel_t p;
    add_write(gnpt_pkg::REG_GRID_RECIPROCAL, recip);
    add_write(gnpt_pkg::REG_CONTRAST_GAIN, gain);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        j.kind = JOB_DRAIN;
        j.pix = '0;
        j.idx = '0;
        j.data = '0;
        j.no_gap = 1'b0;
        job_q.push_back(j);
      end
      p = rand_pixel();
      add_pixel(p.pixel_x, p.pixel_y, calm && i < 120);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: reset configuration, corners and cell edges
    add_pixel(12'd0, 12'd0, 1'b0);
    add_pixel(12'd4095, 12'd4095, 1'b0);
    add_pixel(12'd0, 12'd4095, 1'b0);
    add_pixel(12'd4095, 12'd0, 1'b0);
    add_pixel(12'd1, 12'd1, 1'b0);
    add_pixel(12'd341, 12'd341, 1'b0);
    add_pixel(12'd2048, 12'd2048, 1'b0);
    add_pixel(12'd2730, 12'd1365, 1'b0);
    add_pixel(12'hAAA, 12'h555, 1'b0);
    add_pixel(12'h555, 12'hAAA, 1'b0);
    // zero reciprocal gives zero noise
    add_write(gnpt_pkg::REG_GRID_RECIPROCAL, 25'd0);
    add_pixel(12'd0, 12'd0, 1'b0);
    add_pixel(12'd4095, 12'd4095, 1'b0);
    add_pixel(12'd1234, 12'd3210, 1'b0);
    // unknown indexes are ignored
    add_write(REG_SPARE_A, 25'h1FFFFFF);
    add_write(REG_SPARE_B, 25'h0ABCDEF);
    add_pixel(12'd777, 12'd888, 1'b0);
    // reciprocal above one and full gain saturate
    add_write(gnpt_pkg::REG_GRID_RECIPROCAL, 25'h1FFFFFF);
    add_write(gnpt_pkg::REG_CONTRAST_GAIN, 25'd65535);
    add_pixel(12'd3, 12'd5, 1'b0);
    add_pixel(12'd4095, 12'd1, 1'b0);
    add_pixel(12'd100, 12'd4000, 1'b0);

    add_phase(25'd49200, 25'd19661, 260, 1'b0);
    add_phase(25'd16777216, 25'd65535, 180, 1'b1);
    add_phase(25'd1, 25'd0, 120, 1'b0);
    add_phase(25'd0, 25'd40000, 60, 1'b0);
    add_phase(25'h1FFFFFF, 25'd16384, 160, 1'b0);
    add_phase(25'd262144, 25'd32768, 200, 1'b0);
    for (int k = 0; k < 2; k++)
      add_phase(gnpt_pkg::CFG_DATA_W'($urandom_range(25'h1FFFFFF)),
                gnpt_pkg::CFG_DATA_W'($urandom_range(65535)), 180, 1'b0);
    add_write(REG_SPARE_A, gnpt_pkg::CFG_DATA_W'($urandom_range(25'h1FFFFFF)));
    add_write(REG_SPARE_B, gnpt_pkg::CFG_DATA_W'($urandom_range(25'h1FFFFFF)));
    add_phase(25'd49200, 25'd19661, 40, 1'b0);

    wait (job_q.size() == 0 && !start && !cfg_valid && noise_q.size() == 0);
    repeat (gnpt_pkg::LATENCY + 10) @(posedge clk);
    $display("sent %0d pixels over %0d register writes, checked %0d results",
             pixels_sent, cfg_writes, results_seen);
    $display("%0d results above zero, %0d mismatches", positive_seen, errors);
    if (errors == 0 && noise_q.size() == 0) begin
      $display("PASS gradient_noise_pixel_threshold");
    end else begin
      $display("FAIL gradient_noise_pixel_threshold");
    end
    $finish;
  end

endmodule
